FILE: rtl/core/nwp_pkg.sv
// nwp_pkg: shared types, constants and saturation helper for the Numerov
// wave propagator. No dependencies; used by nwp_ctrl, nwp_datapath and the top.
package nwp_pkg;

	localparam int VALUE_WIDTH_DEF = 48;
	localparam int STEP_W          = 25;
	localparam int FRAC_BITS       = 24;
	localparam int DIV_CYCLES      = 64;
	localparam int CNT_W           = $clog2(DIV_CYCLES);

	// Constants of the recurrence in Q24.24 held in 64 bits
	localparam logic [63:0] C12_Q = 64'(12) << FRAC_BITS;
	localparam logic [63:0] C24_Q = 64'(24) << FRAC_BITS;
	localparam logic [63:0] ONE_Q = 64'(1) << FRAC_BITS;

	// Configuration register indexes
	localparam logic [1:0] CFG_ENERGY = 2'd0;
	localparam logic [1:0] CFG_STEP   = 2'd1;
	localparam logic [1:0] CFG_START0 = 2'd2;
	localparam logic [1:0] CFG_START1 = 2'd3;

	// Multiplier operations, issued in this order
	localparam logic [2:0] OP_E  = 3'd0;  // energy times step, flag only
	localparam logic [2:0] OP_DN = 3'd1;  // g at this point
	localparam logic [2:0] OP_D1 = 3'd2;  // g one point back
	localparam logic [2:0] OP_D2 = 3'd3;  // g two points back
	localparam logic [2:0] OP_Y1 = 3'd4;  // y1 times first coefficient
	localparam logic [2:0] OP_Y2 = 3'd5;  // y2 times second coefficient

	typedef struct packed {
		logic       load;
		logic       diff;
		logic       mul_load;
		logic       mul_step;
		logic       mul_store;
		logic       coef;
		logic       div_load;
		logic       div_step;
		logic       finish;
		logic [2:0] mul_sel;
		logic [1:0] mul_part;
	} cmd_t;

	typedef struct packed {
		logic start_pt;
	} stat_t;

	typedef struct packed {
		logic        ovf;
		logic [63:0] val;
	} s64_t;

	// Clip a signed 128-bit value to signed 64 bits
	function automatic s64_t sat64(input logic [127:0] v);
		s64_t r;
		if (v[127:63] == '0 || v[127:63] == '1) begin
			r.ovf = 1'b0;
			r.val = v[63:0];
		end else begin
			r.ovf = 1'b1;
			r.val = v[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/nwp_ctrl.sv
// nwp_ctrl: sequencer for the Numerov wave propagator.
// Issues cmd_t to nwp_datapath and owns the handshake control; uses nwp_pkg.
module nwp_ctrl import nwp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DIFF   = 4'd1;
	localparam logic [3:0] ST_MLOAD  = 4'd2;
	localparam logic [3:0] ST_MSTEP  = 4'd3;
	localparam logic [3:0] ST_MSTORE = 4'd4;
	localparam logic [3:0] ST_COEF   = 4'd5;
	localparam logic [3:0] ST_DLOAD  = 4'd6;
	localparam logic [3:0] ST_DSTEP  = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0]       state_q, state_d;
	logic [2:0]       op_q, op_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.mul_sel  = op_q;
		cmd.mul_part = cnt_q[1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIFF;
				end
			end
			ST_DIFF: begin
				if (stat.start_pt) begin
					state_d = ST_DONE;
				end else begin
					cmd.diff = 1'b1;
					op_d     = OP_E;
					state_d  = ST_MLOAD;
				end
			end
			ST_MLOAD: begin
				cmd.mul_load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_MSTEP;
			end
			ST_MSTEP: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q[1:0] == 2'd3) state_d = ST_MSTORE;
			end
			ST_MSTORE: begin
				cmd.mul_store = 1'b1;
				op_d          = op_q + 1'b1;
				if (op_q == OP_D2) state_d = ST_COEF;
				else if (op_q == OP_Y2) state_d = ST_DLOAD;
				else state_d = ST_MLOAD;
			end
			ST_COEF: begin
				cmd.coef = 1'b1;
				state_d  = ST_MLOAD;
			end
			ST_DLOAD: begin
				cmd.div_load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DSTEP;
			end
			ST_DSTEP: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_CYCLES - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!(out_valid_q && out_stall)) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance state; hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_E;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("result written over a waiting word");
	a_load_diff: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_DIFF)
		else $error("accepted word not processed");
	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("output valid without a finished word");
	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> $past(cmd.mul_store) && $past(op_q) == OP_Y2)
		else $error("divide started before products were done");

endmodule

FILE: rtl/core/nwp_datapath.sv
// nwp_datapath: configuration, history, shared 32x32 multiplier and
// two-bit-per-cycle restoring divider of the Numerov propagator; uses nwp_pkg.
module nwp_datapath import nwp_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output stat_t                         stat,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [((VALUE_WIDTH > STEP_W) ? VALUE_WIDTH : STEP_W)-1:0] cfg_data,
	input  logic signed [VALUE_WIDTH-1:0] potential_scaled,
	input  logic                          first_point,
	input  logic                          last_point,
	output logic signed [VALUE_WIDTH-1:0] wave_value,
	output logic                          sweep_end,
	output logic                          saturated
);

	localparam logic [1:0] PH_ZERO = 2'd0;
	localparam logic [1:0] PH_ONE  = 2'd1;
	localparam logic [1:0] PH_REC  = 2'd2;

	localparam logic [VALUE_WIDTH-1:0] VMIN_W = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);
	localparam logic [VALUE_WIDTH-1:0] VMAX_W = ~VMIN_W;
	localparam logic [127:0] VMAX_L = (128'(1) << (VALUE_WIDTH - 1)) - 128'(1);
	localparam logic [VALUE_WIDTH-1:0] START1_RST = VALUE_WIDTH'(ONE_Q);

	typedef struct packed {
		logic [63:0]  rem;
		logic [127:0] mq;
	} div_t;

	// One restoring divide step
	function automatic div_t div_bit(input div_t s, input logic [63:0] d);
		div_t        r;
		logic [64:0] t;
		logic        b;
		t = {s.rem, s.mq[127]};
		b = (t >= {1'b0, d});
		if (b) t = t - {1'b0, d};
		r.rem = t[63:0];
		r.mq  = {s.mq[126:0], b};
		return r;
	endfunction

	// Configuration
	logic signed [VALUE_WIDTH-1:0] energy_q, start0_q, start1_q;
	logic [STEP_W-1:0]             step_q;
	// History
	logic signed [VALUE_WIDTH-1:0] y1_q, y2_q, c1_q, c2_q;
	logic [1:0]                    phase_q;
	// Current word
	logic signed [VALUE_WIDTH-1:0] c_in_q;
	logic                          last_in_q;
	logic [1:0]                    phase_eff_q;
	logic                          flag_q;
	// Intermediates
	logic [63:0]  dn_q, d1_q, d2_q, g0_q, g1_q, g2_q, ca_q, cb_q, dv_q;
	logic [127:0] p4_q, acc_q;
	logic [63:0]  ma_q, mb_q;
	logic         mneg_q;
	div_t         div_q, div_d;
	logic [63:0]  dmag_q;
	logic         qneg_q, numneg_q, dzero_q;
	// Output word
	logic [VALUE_WIDTH-1:0] wave_q;
	logic                   sweep_q, sat_q;

	logic [63:0]  e64, cn64, c164, c264, y164, y264;
	logic [64:0]  sub_n, sub_1, sub_2;
	s64_t         s_n, s_1, s_2, s_g, s_m10, s_ca, s_cb, s_dv;
	logic [67:0]  g1x, m10;
	logic [64:0]  ca_sum, cb_sum, dv_sum;
	logic [63:0]  mul_a, mul_b, pp;
	logic [6:0]   pp_sh;
	logic [127:0] prod, prod_sh;
	logic [128:0] num_sum;
	logic [127:0] num;
	logic         num_ovf;
	logic [VALUE_WIDTH-1:0] y_fin;
	logic         y_ovf;

	assign stat.start_pt = (phase_eff_q != PH_REC);

	// Sign-extend stored values to the 64-bit working width
	assign e64  = 64'(energy_q);
	assign cn64 = 64'(c_in_q);
	assign c164 = 64'(c1_q);
	assign c264 = 64'(c2_q);
	assign y164 = 64'(y1_q);
	assign y264 = 64'(y2_q);

	// Differences of energy and potentials
	assign sub_n = {e64[63], e64} - {cn64[63], cn64};
	assign sub_1 = {e64[63], e64} - {c164[63], c164};
	assign sub_2 = {e64[63], e64} - {c264[63], c264};
	assign s_n   = sat64({{63{sub_n[64]}}, sub_n});
	assign s_1   = sat64({{63{sub_1[64]}}, sub_1});
	assign s_2   = sat64({{63{sub_2[64]}}, sub_2});

	// Coefficients of the three-term recurrence
	assign g1x    = {{4{g1_q[63]}}, g1_q};
	assign m10    = (g1x << 3) + (g1x << 1);
	assign s_m10  = sat64({{60{m10[67]}}, m10});
	assign ca_sum = {s_m10.val[63], s_m10.val} + {1'b0, C24_Q};
	assign s_ca   = sat64({{63{ca_sum[64]}}, ca_sum});
	assign cb_sum = {g2_q[63], g2_q} - {1'b0, C12_Q};
	assign s_cb   = sat64({{63{cb_sum[64]}}, cb_sum});
	assign dv_sum = {1'b0, C12_Q} - {g0_q[63], g0_q};
	assign s_dv   = sat64({{63{dv_sum[64]}}, dv_sum});

	// Select multiplier operands
	always_comb begin
		unique case (cmd.mul_sel)
			OP_E:    begin mul_a = e64;  mul_b = 64'(step_q); end
			OP_DN:   begin mul_a = dn_q; mul_b = 64'(step_q); end
			OP_D1:   begin mul_a = d1_q; mul_b = 64'(step_q); end
			OP_D2:   begin mul_a = d2_q; mul_b = 64'(step_q); end
			OP_Y1:   begin mul_a = y164; mul_b = ca_q; end
			OP_Y2:   begin mul_a = y264; mul_b = cb_q; end
			default: begin mul_a = '0;   mul_b = '0; end
		endcase
	end

	// One 32x32 partial product per cycle
	assign pp    = (cmd.mul_part[0] ? ma_q[63:32] : ma_q[31:0])
	             * (cmd.mul_part[1] ? mb_q[63:32] : mb_q[31:0]);
	assign pp_sh = (cmd.mul_part[0] ? 7'd32 : 7'd0) + (cmd.mul_part[1] ? 7'd32 : 7'd0);
	assign prod    = mneg_q ? (128'd0 - acc_q) : acc_q;
	assign prod_sh = {{FRAC_BITS{prod[127]}}, prod[127:FRAC_BITS]};
	assign s_g     = sat64(prod_sh);

	// Numerator sum with clipping
	assign num_sum = {p4_q[127], p4_q} + {prod[127], prod};
	always_comb begin
		num_ovf = (num_sum[128] != num_sum[127]);
		if (num_ovf) num = num_sum[128] ? {1'b1, 127'b0} : {1'b0, {127{1'b1}}};
		else num = num_sum[127:0];
	end

	// Two divide steps per cycle
	always_comb begin
		div_d = div_bit(div_q, dmag_q);
		div_d = div_bit(div_d, dmag_q);
	end

	// Final value with clipping to the output range
	always_comb begin
		y_ovf = 1'b0;
		if (stat.start_pt) begin
			y_fin = (phase_eff_q == PH_ZERO) ? start0_q : start1_q;
		end else if (dzero_q) begin
			y_ovf = 1'b1;
			y_fin = numneg_q ? VMIN_W : VMAX_W;
		end else if (qneg_q) begin
			if (div_q.mq > VMAX_L + 128'd1) begin
				y_ovf = 1'b1;
				y_fin = VMIN_W;
			end else begin
				y_fin = VALUE_WIDTH'(128'd0 - div_q.mq);
			end
		end else begin
			if (div_q.mq > VMAX_L) begin
				y_ovf = 1'b1;
				y_fin = VMAX_W;
			end else begin
				y_fin = div_q.mq[VALUE_WIDTH-1:0];
			end
		end
	end

	// Configuration, history and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			step_q   <= STEP_W'(65536);
			start0_q <= '0;
			start1_q <= START1_RST;
			y1_q     <= '0;
			y2_q     <= '0;
			c1_q     <= '0;
			c2_q     <= '0;
			phase_q  <= PH_ZERO;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENERGY: energy_q <= cfg_data[VALUE_WIDTH-1:0];
					CFG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
					CFG_START0: start0_q <= cfg_data[VALUE_WIDTH-1:0];
					CFG_START1: start1_q <= cfg_data[VALUE_WIDTH-1:0];
				endcase
			end
			if (cmd.finish) begin
				y2_q <= y1_q;
				y1_q <= y_fin;
				c2_q <= c1_q;
				c1_q <= c_in_q;
				if (last_in_q) phase_q <= PH_ZERO;
				else if (phase_eff_q == PH_ZERO) phase_q <= PH_ONE;
				else phase_q <= PH_REC;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_in_q      <= potential_scaled;
			last_in_q   <= last_point;
			phase_eff_q <= first_point ? PH_ZERO : ((phase_q == PH_ZERO) ? PH_ZERO
			               : ((phase_q == PH_ONE) ? PH_ONE : PH_REC));
			flag_q      <= 1'b0;
		end
		if (cmd.diff) begin
			dn_q   <= s_n.val;
			d1_q   <= s_1.val;
			d2_q   <= s_2.val;
			flag_q <= flag_q | s_n.ovf | s_1.ovf | s_2.ovf;
		end
		if (cmd.mul_load) begin
			ma_q   <= mul_a[63] ? (64'd0 - mul_a) : mul_a;
			mb_q   <= mul_b[63] ? (64'd0 - mul_b) : mul_b;
			mneg_q <= mul_a[63] ^ mul_b[63];
			acc_q  <= '0;
		end
		if (cmd.mul_step) acc_q <= acc_q + ({64'd0, pp} << pp_sh);
		if (cmd.mul_store) begin
			unique case (cmd.mul_sel)
				OP_E:    flag_q <= flag_q | s_g.ovf;
				OP_DN:   begin g0_q <= s_g.val; flag_q <= flag_q | s_g.ovf; end
				OP_D1:   begin g1_q <= s_g.val; flag_q <= flag_q | s_g.ovf; end
				OP_D2:   begin g2_q <= s_g.val; flag_q <= flag_q | s_g.ovf; end
				OP_Y1:   p4_q <= prod;
				default: ;
			endcase
		end
		if (cmd.coef) begin
			ca_q   <= s_ca.val;
			cb_q   <= s_cb.val;
			dv_q   <= s_dv.val;
			flag_q <= flag_q | s_m10.ovf | s_ca.ovf | s_cb.ovf | s_dv.ovf;
		end
		// Divider load happens with the last product still in the accumulator
		if (cmd.div_load) begin
			numneg_q  <= num[127];
			div_q.rem <= '0;
			div_q.mq  <= num[127] ? (128'd0 - num) : num;
			dmag_q    <= dv_q[63] ? (64'd0 - dv_q) : dv_q;
			qneg_q    <= num[127] ^ dv_q[63];
			dzero_q   <= (dv_q == '0);
			flag_q    <= flag_q | num_ovf;
		end
		if (cmd.div_step) div_q <= div_d;
		if (cmd.finish) begin
			wave_q  <= y_fin;
			sweep_q <= last_in_q;
			sat_q   <= stat.start_pt ? 1'b0 : (flag_q | y_ovf);
		end
	end

	assign wave_value = wave_q;
	assign sweep_end  = sweep_q;
	assign saturated  = sat_q;

endmodule

FILE: rtl/core/numerov_wave_propagator.sv
// numerov_wave_propagator: top level of the Numerov wave propagator.
// Joins nwp_ctrl and nwp_datapath; uses nwp_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  in       | in_valid / in_stall   | potential_scaled, first_point, last_point
//  out      | out_valid / out_stall | wave_value, sweep_end, saturated
//  cfg      | cfg_we                | cfg_index, cfg_data
//
// A start point passes from accept to result through the idle, difference and
// done states; a recurrence point runs six products on one 32x32 multiplier and a
// 128-by-64 restoring divide at two quotient bits per cycle.
// Reset clears history, so the first word after reset is grid point zero.
// A new word is accepted while the previous result waits in the output register;
// a stalled output holds the finished word until the output register frees.
module numerov_wave_propagator import nwp_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [((VALUE_WIDTH > STEP_W) ? VALUE_WIDTH : STEP_W)-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] potential_scaled,
	input  logic                          first_point,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] wave_value,
	output logic                          sweep_end,
	output logic                          saturated
);

	cmd_t  cmd;
	stat_t stat;

	nwp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	nwp_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.potential_scaled (potential_scaled),
		.first_point      (first_point),
		.last_point       (last_point),
		.wave_value       (wave_value),
		.sweep_end        (sweep_end),
		.saturated        (saturated)
	);

endmodule

FILE: tb/tb_numerov_wave_propagator.sv
// tb_numerov_wave_propagator: self-checking bench for the Numerov wave propagator.
// Drives a directed table, then random sweeps; checks results against the table or
// a Q24.24 recurrence predictor. Depends on nwp_pkg and numerov_wave_propagator.
module tb_numerov_wave_propagator;
	import nwp_pkg::*;

	localparam int VW = VALUE_WIDTH_DEF;
	localparam logic signed [VW-1:0] WMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] WMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] WONE = 1 <<< FRAC_BITS;
	localparam logic signed [127:0] Q10 = 128'sd10;
	localparam logic signed [127:0] Q12 = 128'sd12 <<< FRAC_BITS;
	localparam logic signed [127:0] Q24 = 128'sd24 <<< FRAC_BITS;
	localparam int DRAIN_CYCLES = 120;

	typedef struct packed {
		logic signed [VW-1:0] val;
		logic                 sweep_end;
		logic                 sat;
	} wave_word_t;

	typedef struct {
		bit                   is_cfg;
		logic [1:0]           idx;
		logic [VW-1:0]        data;
		logic signed [VW-1:0] pot;
		bit                   first;
		bit                   last;
		bit                   has_exp;
		logic signed [VW-1:0] exp_val;
	} script_row_t;

	logic                 clk, arst_n;
	logic                 cfg_we;
	logic [1:0]           cfg_index;
	logic [VW-1:0]        cfg_data;
	logic                 in_valid, in_stall;
	logic signed [VW-1:0] potential_scaled;
	logic                 first_point, last_point;
	logic                 out_valid, out_stall;
	logic signed [VW-1:0] wave_value;
	logic                 sweep_end, saturated;

	// predictor copy of configuration and history
	logic signed [VW-1:0] energy, start_first, start_second;
	logic [STEP_W-1:0]    step_sq;
	logic signed [VW-1:0] y_back1, y_back2, c_back1, c_back2;
	logic [1:0]           phase;

	wave_word_t wave_q[$];
	int  errors;
	bit  cur_has_exp;
	logic signed [VW-1:0] cur_exp;
	script_row_t script[];

	numerov_wave_propagator dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 3_000_000);
		$display("tb_numerov_wave_propagator: FAIL");
		$finish;
	end

	// clip a 128-bit signed value to 64 bits, flagging any clip
	function automatic logic signed [63:0] clip64(input logic signed [127:0] v,
			inout logic flag);
		if (v[127:63] == '0 || v[127:63] == '1)
			return v[63:0];
		flag = 1'b1;
		return v[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
	endfunction

	function automatic logic signed [63:0] scale_by_step(input logic signed [63:0] d,
			inout logic flag);
		logic signed [127:0] p;
		p = d * $signed({1'b0, step_sq});
		return clip64(p >>> FRAC_BITS, flag);
	endfunction

	// advance the recurrence by one grid point
	function automatic wave_word_t numerov_next(input logic signed [VW-1:0] c,
			input logic first, input logic last);
		logic flag;
		logic signed [63:0] dn, d1, d2, g0, g1, g2, ca, cb, dv;
		logic signed [127:0] num;
		logic [127:0] mag, dmag, q;
		logic neg;
		logic signed [VW-1:0] y;
		wave_word_t w;
		flag = 1'b0;
		if (first)
			phase = 2'd0;
		if (phase == 2'd0) begin
			y = start_first;
			phase = 2'd1;
		end else if (phase == 2'd1) begin
			y = start_second;
			phase = 2'd2;
		end else begin
			dn = clip64(128'(energy) - 128'(c), flag);
			d1 = clip64(128'(energy) - 128'(c_back1), flag);
			d2 = clip64(128'(energy) - 128'(c_back2), flag);
			g0 = scale_by_step(dn, flag);
			g1 = scale_by_step(d1, flag);
			g2 = scale_by_step(d2, flag);
			ca = clip64(128'(clip64(128'(g1) * Q10, flag)) + Q24, flag);
			cb = clip64(128'(g2) - Q12, flag);
			dv = clip64(Q12 - 128'(g0), flag);
			num = 128'(y_back1) * 128'(ca) + 128'(y_back2) * 128'(cb);
			if (dv == 0) begin
				flag = 1'b1;
				y = num[127] ? WMIN : WMAX;
			end else begin
				mag  = num[127] ? -num : num;
				dmag = dv[63] ? -128'(dv) : 128'(dv);
				q    = mag / dmag;
				neg  = num[127] ^ dv[63];
				if (neg) begin
					if (q > 128'(WMAX) + 1) begin
						flag = 1'b1;
						y = WMIN;
					end else
						y = -q[VW-1:0];
				end else if (q > 128'(WMAX)) begin
					flag = 1'b1;
					y = WMAX;
				end else
					y = q[VW-1:0];
			end
		end
		y_back2 = y_back1;
		y_back1 = y;
		c_back2 = c_back1;
		c_back1 = c;
		if (last)
			phase = 2'd0;
		w.val = y;
		w.sweep_end = last;
		w.sat = flag;
		return w;
	endfunction

	// track config writes, predict accepted words, check results
	always @(posedge clk) begin
		wave_word_t w, e;
		if (cfg_we) begin
			case (cfg_index)
				CFG_ENERGY: energy <= cfg_data;
				CFG_STEP:   step_sq <= cfg_data[STEP_W-1:0];
				CFG_START0: start_first <= cfg_data;
				CFG_START1: start_second <= cfg_data;
			endcase
		end
		if (in_valid && !in_stall) begin
			w = numerov_next(potential_scaled, first_point, last_point);
			if (cur_has_exp) begin
				w.val = cur_exp;
				w.sat = 1'b0;
			end
			wave_q.push_back(w);
		end
		if (out_valid && !out_stall) begin
			if (wave_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, actual value=%0d end=%b sat=%b",
					$time, wave_value, sweep_end, saturated);
			end else begin
				e = wave_q.pop_front();
				if (wave_value !== e.val || sweep_end !== e.sweep_end
						|| saturated !== e.sat) begin
					errors++;
					$display("%0t: mismatch expected value=%0d end=%b sat=%b, actual value=%0d end=%b sat=%b",
						$time, e.val, e.sweep_end, e.sat, wave_value, sweep_end, saturated);
				end
			end
		end
	end

	// receiver: stall pattern of its own, with one long hold-off
	initial begin
		int cycle, mode;
		cycle = 0;
		mode = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			cycle++;
			if (cycle % 64 == 0)
				mode = $urandom_range(0, 3);
			if (cycle >= 20000 && cycle < 20800)
				out_stall <= 1'b1;
			else case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				2: out_stall <= cycle[0];
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_word(input logic signed [VW-1:0] pot, input bit first,
			input bit last, input bit has_exp, input logic signed [VW-1:0] exp_val);
		@(negedge clk);
		in_valid <= 1'b1;
		potential_scaled <= pot;
		first_point <= first;
		last_point <= last;
		cur_has_exp = has_exp;
		cur_exp = exp_val;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
	endtask

	task automatic idle_sender(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// hold input until every expected word has arrived, then let the core settle
	task automatic drain();
		idle_sender(1);
		while (wave_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [VW-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [VW-1:0] rand_wide();
		return VW'({$urandom(), $urandom()});
	endfunction

	function automatic logic signed [VW-1:0] rand_near(input int bits);
		return $signed(VW'($urandom_range(0, (1 << bits) - 1))) - (VW'(1) <<< (bits - 1));
	endfunction

	initial begin
		int sent, len;
		bit wide, f, l;
		errors = 0;
		cur_has_exp = 1'b0;
		cur_exp = '0;
		energy = '0;
		step_sq = 65536;
		start_first = '0;
		start_second = WONE;
		y_back1 = '0;
		y_back2 = '0;
		c_back1 = '0;
		c_back2 = '0;
		phase = 2'd0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENERGY;
		cfg_data = '0;
		in_valid = 1'b0;
		potential_scaled = '0;
		first_point = 1'b0;
		last_point = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		script = '{
			// start points straight after reset, then field extremes
			'{0, CFG_ENERGY, 0, 0, 0, 0, 1, 0},
			'{0, CFG_ENERGY, 0, WMAX, 0, 0, 1, WONE},
			'{0, CFG_ENERGY, 0, WMIN, 0, 0, 0, 0},
			'{0, CFG_ENERGY, 0, 0, 0, 0, 0, 0},
			'{0, CFG_ENERGY, 0, WMAX, 0, 1, 0, 0},
			// after the last point, restart without a first marker
			'{0, CFG_ENERGY, 0, 0, 0, 0, 1, 0},
			'{0, CFG_ENERGY, 0, 1, 0, 0, 1, WONE},
			// first marker in mid sweep
			'{0, CFG_ENERGY, 0, -1, 1, 0, 1, 0},
			'{0, CFG_ENERGY, 0, 0, 0, 0, 1, WONE},
			'{0, CFG_ENERGY, 0, 5 <<< FRAC_BITS, 0, 1, 0, 0},
			// zero divisor: energy minus potential equals twelve at unit step
			'{1, CFG_ENERGY, 12 <<< FRAC_BITS, 0, 0, 0, 0, 0},
			'{1, CFG_STEP, 1 << FRAC_BITS, 0, 0, 0, 0, 0},
			'{1, CFG_START0, WMAX, 0, 0, 0, 0, 0},
			'{1, CFG_START1, WMIN, 0, 0, 0, 0, 0},
			'{0, CFG_ENERGY, 0, 0, 1, 0, 1, WMAX},
			'{0, CFG_ENERGY, 0, 0, 0, 0, 1, WMIN},
			'{0, CFG_ENERGY, 0, 0, 0, 0, 0, 0},
			'{0, CFG_ENERGY, 0, WMIN, 0, 0, 0, 0},
			'{0, CFG_ENERGY, 0, WMAX, 0, 1, 0, 0},
			// zero step and most negative energy: result overflow
			'{1, CFG_STEP, 0, 0, 0, 0, 0, 0},
			'{1, CFG_ENERGY, WMIN, 0, 0, 0, 0, 0},
			'{0, CFG_ENERGY, 0, WMAX, 1, 0, 1, WMAX},
			'{0, CFG_ENERGY, 0, WMIN, 0, 0, 1, WMIN},
			'{0, CFG_ENERGY, 0, 0, 0, 1, 0, 0}
		};
		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				if (i == 0 || !script[i-1].is_cfg)
					drain();
				cfg_write(script[i].idx, script[i].data);
			end else
				send_word(script[i].pot, script[i].first, script[i].last,
					script[i].has_exp, script[i].exp_val);
		end

		// random phases, each under its own configuration
		for (int ph = 0; ph < 10; ph++) begin
			drain();
			wide = (ph % 3 == 0);
			cfg_write(CFG_ENERGY, wide ? rand_wide() : rand_near(30));
			cfg_write(CFG_STEP, ph == 1 ? (1 << FRAC_BITS) : ph == 2 ? 0 :
				$urandom_range(0, ph % 2 ? (1 << FRAC_BITS) : (1 << 18)));
			cfg_write(CFG_START0, wide ? rand_wide() : rand_near(26));
			cfg_write(CFG_START1, wide ? rand_wide() : rand_near(26));
			sent = 0;
			while (sent < 200) begin
				len = $urandom_range(2, 30);
				for (int k = 0; k < len; k++) begin
					f = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
					l = (k == len - 1) ? ($urandom_range(0, 9) != 0)
						: ($urandom_range(0, 49) == 0);
					send_word(wide ? rand_wide() : rand_near(30), f, l, 1'b0, '0);
					sent++;
					if ($urandom_range(0, 3) == 0)
						idle_sender($urandom_range(1, 15));
				end
			end
		end

		drain();
		if (errors == 0 && wave_q.size() == 0)
			$display("tb_numerov_wave_propagator: PASS");
		else
			$display("tb_numerov_wave_propagator: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/nwp_pkg.sv
rtl/core/nwp_ctrl.sv
rtl/core/nwp_datapath.sv
rtl/core/numerov_wave_propagator.sv
tb/tb_numerov_wave_propagator.sv
